// ----- src/sfr_pkg.sv -----
// Shared types, constants and helper functions for the stream find-and-replace block.
`timescale 1ns / 1ps
package sfr_pkg;

  // Deepest window the design is built for; the pattern register caps at 8 bytes.
  localparam int MAX_LEN   = 8;
  localparam int LEN_CAP   = (MAX_LEN < 8) ? MAX_LEN : 8;
  localparam int IDX_W     = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
  localparam int LEN_W     = $clog2(LEN_CAP + 1);

  // One request can produce up to eight output bytes.
  localparam int BURST_D   = 8;
  localparam int CNT_W     = $clog2(BURST_D + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [BURST_D-1:0][7:0] data;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } burst_t;

  // Zero acts as one, anything above the window depth saturates.
  function automatic logic [LEN_W-1:0] eff_plen(input logic [3:0] v);
    logic [LEN_W-1:0] r;
    if (v == 4'd0) begin
      r = LEN_W'(1);
    end else if (int'(v) > LEN_CAP) begin
      r = LEN_W'(LEN_CAP);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_rlen(input logic [3:0] v);
    logic [CNT_W-1:0] r;
    if (v == 4'd0) begin
      r = CNT_W'(1);
    end else if (int'(v) > BURST_D) begin
      r = CNT_W'(BURST_D);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- src/sfr_core.sv -----
// Match window: holds recent bytes, compares against the pattern and builds the output burst.
`timescale 1ns / 1ps
module sfr_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          clear,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  input  logic [sfr_pkg::LEN_W-1:0]     plen,
  input  logic [sfr_pkg::CFG_DW-1:0]    pattern,
  input  logic [sfr_pkg::CNT_W-1:0]     rlen,
  input  logic [sfr_pkg::CFG_DW-1:0]    replacement,
  output logic                          ld,
  output sfr_pkg::burst_t               burst
);

  sfr_pkg::byte_t                   win_r   [sfr_pkg::LEN_CAP];
  sfr_pkg::byte_t                   win_nxt [sfr_pkg::LEN_CAP];
  sfr_pkg::byte_t                   win_ins [sfr_pkg::LEN_CAP];
  logic [sfr_pkg::IDX_W-1:0]        fill_r;
  logic [sfr_pkg::IDX_W-1:0]        fill_nxt;
  logic [sfr_pkg::LEN_W-1:0]        fill_inc;
  logic                             full;
  logic                             hit;

  always_comb begin
    win_ins = win_r;
    win_ins[fill_r] = in_byte;
    fill_inc = sfr_pkg::LEN_W'(fill_r) + sfr_pkg::LEN_W'(1);
    full = (fill_inc == plen);
    hit = full;
    for (int i = 0; i < sfr_pkg::LEN_CAP; i++) begin
      if ((sfr_pkg::LEN_W'(i) < plen) && (win_ins[i] != pattern[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    burst.data = '0;
    burst.cnt  = '0;
    burst.last = 1'b0;
    win_nxt    = win_ins;
    fill_nxt   = fill_r;
    if (hit) begin
      for (int i = 0; i < sfr_pkg::BURST_D; i++) begin
        burst.data[i] = replacement[8*i +: 8];
      end
      burst.cnt  = rlen;
      burst.last = in_last;
      fill_nxt   = '0;
    end else if (in_last) begin
      // End of stream: flush everything held, oldest first.
      for (int i = 0; i < sfr_pkg::LEN_CAP; i++) begin
        burst.data[i] = win_ins[i];
      end
      burst.cnt  = sfr_pkg::CNT_W'(fill_inc);
      burst.last = 1'b1;
      fill_nxt   = '0;
    end else if (full) begin
      // No match on a full window: release the oldest byte and slide.
      burst.data[0] = win_ins[0];
      burst.cnt     = sfr_pkg::CNT_W'(1);
      for (int i = 0; i < sfr_pkg::LEN_CAP - 1; i++) begin
        win_nxt[i] = win_ins[i + 1];
      end
      fill_nxt = sfr_pkg::IDX_W'(plen - sfr_pkg::LEN_W'(1));
    end else begin
      fill_nxt = sfr_pkg::IDX_W'(fill_inc);
    end
  end

  assign ld = accept && (burst.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (clear) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ----- src/sfr_burst.sv -----
// Output buffer that plays out one burst of result bytes, one byte per cycle while out_ready is high.
`timescale 1ns / 1ps
module sfr_burst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld,
  input  sfr_pkg::burst_t      burst,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [sfr_pkg::BURST_D-1:0][7:0] buf_r;
  logic [sfr_pkg::BURST_D-1:0][7:0] buf_nxt;
  logic [sfr_pkg::CNT_W-1:0]        cnt_r;
  logic [sfr_pkg::CNT_W-1:0]        cnt_nxt;
  logic                             last_r;
  logic                             last_nxt;
  logic                             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt_r == '0) || ((cnt_r == sfr_pkg::CNT_W'(1)) && out_ready);
  assign out_byte  = buf_r[0];
  assign out_last  = last_r && (cnt_r == sfr_pkg::CNT_W'(1));

  always_comb begin
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (ld) begin
      buf_nxt  = burst.data;
      cnt_nxt  = burst.cnt;
      last_nxt = burst.last;
    end else if (pop) begin
      for (int i = 0; i < sfr_pkg::BURST_D - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
      cnt_nxt = cnt_r - sfr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      last_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > sfr_pkg::CNT_W'(1)) |-> !in_ready)
    else $error("input taken while more than one result byte is pending");

  a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> ((cnt_r == '0) || ((cnt_r == sfr_pkg::CNT_W'(1)) && out_ready)))
    else $error("burst loaded over bytes not yet delivered");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !ld) |=> (cnt_r == sfr_pkg::CNT_W'($past(cnt_r) - sfr_pkg::CNT_W'(1))))
    else $error("byte count did not step down after a delivered byte");

endmodule

// ----- src/stream_find_replace.sv -----
// Top level of the streaming find-and-replace block: configuration registers and datapath.
`timescale 1ns / 1ps
// Streaming find-and-replace over a byte stream.
// Input requests (in_byte, in_last) arrive on a valid/ready channel. Each
// occurrence of the configured pattern (1 to 8 bytes) is replaced by the
// configured replacement (1 to 8 bytes), leftmost and non-overlapping.
// Result requests (out_byte, out_last) leave on a second valid/ready channel;
// out_last marks the final byte produced for a request that carried in_last.
//
// The results of a request are registered in the output buffer when it is accepted
// and presented from the next cycle on, one byte per cycle while out_ready is high.
// Throughput is one request per cycle while each request yields at most one byte and
// the receiver is ready. A request that yields a burst of more than one byte (a
// replacement, or the flush at end of stream) holds off new input until the single
// output buffer has played the burst out, because that buffer takes the next request
// as its last byte leaves. Configuration uses cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, which the block leaves unchecked. Writing the
// pattern length empties the match window. Reset (rst_n low, synchronous) empties
// the window and output buffer and returns the registers to pattern 0, length 1,
// replacement 0, length 1. When the receiver stalls, the waiting byte holds and
// input is refused until the buffer's last byte is taken.
module stream_find_replace (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfr_pkg::CFG_DW-1:0]        cfg_data
);

  // Lengths are stored already clamped to their legal ranges.
  logic [sfr_pkg::CFG_DW-1:0] pattern_r;
  logic [sfr_pkg::LEN_W-1:0]  plen_r;
  logic [sfr_pkg::CFG_DW-1:0] repl_r;
  logic [sfr_pkg::CNT_W-1:0]  rlen_r;

  logic                       accept;
  logic                       clear;
  logic                       ld;
  sfr_pkg::burst_t            burst;

  assign accept = in_valid && in_ready;
  assign clear  = cfg_we && (cfg_index == sfr_pkg::REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= sfr_pkg::LEN_W'(1);
      repl_r    <= '0;
      rlen_r    <= sfr_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_PATTERN_BYTES:      pattern_r <= cfg_data;
        sfr_pkg::REG_PATTERN_LENGTH:     plen_r    <= sfr_pkg::eff_plen(cfg_data[3:0]);
        sfr_pkg::REG_REPLACEMENT_BYTES:  repl_r    <= cfg_data;
        sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_r    <= sfr_pkg::eff_rlen(cfg_data[3:0]);
        default: begin
        end
      endcase
    end
  end

  // Window compare and burst assembly.
  sfr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .clear       (clear),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .plen        (plen_r),
    .pattern     (pattern_r),
    .rlen        (rlen_r),
    .replacement (repl_r),
    .ld          (ld),
    .burst       (burst)
  );

  // Registered output side; it also decides when the next request may enter.
  sfr_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .burst     (burst),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
